// ----- sv/gre_pkg.sv -----
// Shared types, constants and colour conversion for the glyph row pixel expander.
`default_nettype none

package gre_pkg;

    // Glyph geometry limits
    localparam int MAX_GLYPH_WIDTH = 8;
    localparam int MAX_SCALE       = 8;

    // Field widths
    localparam int COORD_IN_W  = 11;
    localparam int COORD_W     = 10;
    localparam int POS_W       = 12;
    localparam int ROW_BITS_W  = 8;
    localparam int SRC_ROW_W   = 5;
    localparam int REP_ROW_W   = 3;
    localparam int COLOUR_W    = 16;
    localparam int RGB_W       = 24;
    localparam int SIZE_W      = 4;
    localparam int STEP_W      = 3;

    // Configuration register indexes
    localparam logic [2:0] REG_FG_COLOUR      = 3'd0;
    localparam logic [2:0] REG_BG_COLOUR      = 3'd1;
    localparam logic [2:0] REG_TRANSPARENT_BG = 3'd2;
    localparam logic [2:0] REG_GLYPH_WIDTH    = 3'd3;
    localparam logic [2:0] REG_PIXEL_SCALE    = 3'd4;
    localparam logic [2:0] REG_SCREEN_WIDTH   = 3'd5;
    localparam logic [2:0] REG_SCREEN_HEIGHT  = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_FLUSH
    } walk_state_t;

    // Configuration as seen by the walker
    typedef struct packed {
        logic [COLOUR_W-1:0] fg565;
        logic [COLOUR_W-1:0] bg565;
        logic                transparent_bg;
        logic [SIZE_W-1:0]   glyph_width;
        logic [SIZE_W-1:0]   pixel_scale;
        logic [COORD_W-1:0]  screen_width;
        logic [COORD_W-1:0]  screen_height;
    } cfg_t;

    // Candidate pixel or end-of-item marker from walker to output stage
    typedef struct packed {
        logic                valid;
        logic                flush;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COLOUR_W-1:0] colour;
    } cand_t;

    // RGB888 to RGB565
    function automatic logic [COLOUR_W-1:0] to565(input logic [RGB_W-1:0] c);
        return {c[23:19], c[15:10], c[7:3]};
    endfunction

endpackage

`default_nettype wire

// ----- sv/glyph_row_pixel_expander.sv -----
// Flow: an item's first pixel passes the item registers and the setup and run states into
// the held-pixel register; m_tvalid rises for it once the next pixel or the end-of-item
// marker arrives, so it waits longer when the positions after it are clipped or blank.
// Steps of one row item: accept, setup, one walker step per expanded pixel position
// (held while the output stage stalls), one end-of-item step; a row rejected whole (row
// y off screen, zero width or scale, repeat beyond scale) goes back to idle after setup.
// Reset: synchronous active-low aresetn empties both stages and restores the
// register defaults (width 8, scale 1, screen 320x320, colours black, opaque).
`default_nettype none

module glyph_row_pixel_expander
    import gre_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    // Row items in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // origin_x[10:0], origin_y[21:11], row_bits[29:22],
                                       // source_row[34:30], repeat_row[37:35], zero pad
    // Pixels out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // pixel_x[9:0], pixel_y[19:10], pixel_colour[35:20],
                                       // zero pad
    output logic             m_tlast   // last_pixel
);

    logic [RGB_W-1:0]    fg_colour_reg, bg_colour_reg;
    logic                transparent_bg_reg;
    logic [SIZE_W-1:0]   glyph_width_reg, pixel_scale_reg;
    logic [COORD_W-1:0]  screen_width_reg, screen_height_reg;

    cfg_t                cfg;
    cand_t               cand;
    logic                cand_ready;
    logic [COORD_W-1:0]  pixel_x, pixel_y;
    logic [COLOUR_W-1:0] pixel_colour;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_colour_reg      <= '0;
            bg_colour_reg      <= '0;
            transparent_bg_reg <= 1'b0;
            glyph_width_reg    <= SIZE_W'(8);
            pixel_scale_reg    <= SIZE_W'(1);
            screen_width_reg   <= COORD_W'(320);
            screen_height_reg  <= COORD_W'(320);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FG_COLOUR:      fg_colour_reg      <= cfg_data;
                REG_BG_COLOUR:      bg_colour_reg      <= cfg_data;
                REG_TRANSPARENT_BG: transparent_bg_reg <= cfg_data[0];
                REG_GLYPH_WIDTH:    glyph_width_reg    <= cfg_data[SIZE_W-1:0];
                REG_PIXEL_SCALE:    pixel_scale_reg    <= cfg_data[SIZE_W-1:0];
                REG_SCREEN_WIDTH:   screen_width_reg   <= cfg_data[COORD_W-1:0];
                REG_SCREEN_HEIGHT:  screen_height_reg  <= cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.fg565          = to565(fg_colour_reg);
        cfg.bg565          = to565(bg_colour_reg);
        cfg.transparent_bg = transparent_bg_reg;
        cfg.glyph_width    = glyph_width_reg;
        cfg.pixel_scale    = pixel_scale_reg;
        cfg.screen_width   = screen_width_reg;
        cfg.screen_height  = screen_height_reg;
    end

    gre_walker u_walker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_i        (cfg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .origin_x_i   (s_tdata[10:0]),
        .origin_y_i   (s_tdata[21:11]),
        .row_bits_i   (s_tdata[29:22]),
        .source_row_i (s_tdata[34:30]),
        .repeat_row_i (s_tdata[37:35]),
        .cand_o       (cand),
        .cand_ready_i (cand_ready)
    );

    gre_out_stage u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cand_i         (cand),
        .cand_ready_o   (cand_ready),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .pixel_x_o      (pixel_x),
        .pixel_y_o      (pixel_y),
        .pixel_colour_o (pixel_colour),
        .m_tlast        (m_tlast)
    );

    assign m_tdata = {4'b0000, pixel_colour, pixel_y, pixel_x};

endmodule

`default_nettype wire

// ----- sv/gre_walker.sv -----
// Row walker: shifts the glyph row out one bit per source pixel and steps x per pixel.
`default_nettype none

module gre_walker
    import gre_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cfg_t                  cfg_i,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [COORD_IN_W-1:0] origin_x_i,
    input  wire logic [COORD_IN_W-1:0] origin_y_i,
    input  wire logic [ROW_BITS_W-1:0] row_bits_i,
    input  wire logic [SRC_ROW_W-1:0]  source_row_i,
    input  wire logic [REP_ROW_W-1:0]  repeat_row_i,
    output cand_t                      cand_o,
    input  wire logic                  cand_ready_i
);

    walk_state_t state_reg, state_next;

    logic [COORD_IN_W-1:0] ox_reg, oy_reg;
    logic [ROW_BITS_W-1:0] bits_reg;
    logic [SRC_ROW_W-1:0]  srow_reg;
    logic [REP_ROW_W-1:0]  rrow_reg;

    logic [POS_W-1:0]      x_reg;
    logic [COORD_W-1:0]    y_reg;
    logic [ROW_BITS_W-1:0] sh_reg;
    logic [STEP_W-1:0]     m_reg, k_reg;
    logic [STEP_W-1:0]     s_last_reg, w_last_reg;

    logic [SIZE_W-1:0]     w_eff, s_eff;
    logic [SIZE_W-1:0]     align;
    logic [SRC_ROW_W+SIZE_W-1:0] row_off;
    logic [POS_W-1:0]      y_pos;
    logic                  drop;
    logic                  emit;
    logic                  advance;
    logic                  last_step;

    // Saturated width and scale
    always_comb begin
        w_eff = (cfg_i.glyph_width > SIZE_W'(MAX_GLYPH_WIDTH)) ?
                SIZE_W'(MAX_GLYPH_WIDTH) : cfg_i.glyph_width;
        s_eff = (cfg_i.pixel_scale > SIZE_W'(MAX_SCALE)) ?
                SIZE_W'(MAX_SCALE) : cfg_i.pixel_scale;
        align = SIZE_W'(MAX_GLYPH_WIDTH) - w_eff;
    end

    // Row y and early rejection
    always_comb begin
        row_off = SRC_ROW_W'(srow_reg) * s_eff;
        y_pos   = {oy_reg[COORD_IN_W-1], oy_reg}
                + POS_W'(row_off) + POS_W'(rrow_reg);
        drop    = (w_eff == '0) || (s_eff == '0)
                || ({1'b0, rrow_reg} >= s_eff)
                || y_pos[POS_W-1]
                || (y_pos >= {2'b00, cfg_i.screen_height});
    end

    // Current pixel: leftmost remaining bit, clipped to the screen
    always_comb begin
        emit = (sh_reg[ROW_BITS_W-1] || !cfg_i.transparent_bg)
             && !x_reg[POS_W-1]
             && (x_reg < {2'b00, cfg_i.screen_width});
        advance   = !emit || cand_ready_i;
        last_step = (m_reg == s_last_reg) && (k_reg == w_last_reg);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_SETUP;
            ST_SETUP: state_next = drop ? ST_IDLE : ST_RUN;
            ST_RUN:   if (advance && last_step) state_next = ST_FLUSH;
            ST_FLUSH: if (cand_ready_i) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_tready      = 1'b0;
        cand_o.valid  = 1'b0;
        cand_o.flush  = 1'b0;
        cand_o.x      = x_reg[COORD_W-1:0];
        cand_o.y      = y_reg;
        cand_o.colour = sh_reg[ROW_BITS_W-1] ? cfg_i.fg565 : cfg_i.bg565;
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_SETUP: ;
            ST_RUN:   cand_o.valid = emit;
            ST_FLUSH: cand_o.flush = 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Item capture, setup and per-pixel stepping
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ox_reg   <= origin_x_i;
                    oy_reg   <= origin_y_i;
                    bits_reg <= row_bits_i;
                    srow_reg <= source_row_i;
                    rrow_reg <= repeat_row_i;
                end
            end
            ST_SETUP: begin
                x_reg      <= {ox_reg[COORD_IN_W-1], ox_reg};
                y_reg      <= y_pos[COORD_W-1:0];
                sh_reg     <= bits_reg << align;
                m_reg      <= '0;
                k_reg      <= '0;
                s_last_reg <= STEP_W'(s_eff - 1'b1);
                w_last_reg <= STEP_W'(w_eff - 1'b1);
            end
            ST_RUN: begin
                if (advance) begin
                    x_reg <= x_reg + 1'b1;
                    if (m_reg == s_last_reg) begin
                        m_reg  <= '0;
                        k_reg  <= k_reg + 1'b1;
                        sh_reg <= {sh_reg[ROW_BITS_W-2:0], 1'b0};
                    end else begin
                        m_reg <= m_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/gre_out_stage.sv -----
// Output stage: holds one pixel back so the final pixel of an item can carry tlast.
`default_nettype none

module gre_out_stage
    import gre_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cand_t               cand_i,
    output logic                     cand_ready_o,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [COORD_W-1:0]       pixel_x_o,
    output logic [COORD_W-1:0]       pixel_y_o,
    output logic [COLOUR_W-1:0]      pixel_colour_o,
    output logic                     m_tlast
);

    logic                pend_valid_reg;
    logic [COORD_W-1:0]  pend_x_reg, pend_y_reg;
    logic [COLOUR_W-1:0] pend_colour_reg;

    logic                out_valid_reg;
    logic                out_last_reg;
    logic [COORD_W-1:0]  out_x_reg, out_y_reg;
    logic [COLOUR_W-1:0] out_colour_reg;

    logic out_free;
    logic push_out;

    // Held pixel moves on when a new one arrives or the item ends, once the output register is free
    always_comb begin
        out_free     = !out_valid_reg || m_tready;
        cand_ready_o = !pend_valid_reg || out_free;
        push_out     = pend_valid_reg && out_free && (cand_i.valid || cand_i.flush);
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (push_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cand_i.valid && cand_ready_o) begin
                pend_valid_reg <= 1'b1;
            end else if (cand_i.flush && push_out) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (push_out) begin
            out_x_reg      <= pend_x_reg;
            out_y_reg      <= pend_y_reg;
            out_colour_reg <= pend_colour_reg;
            out_last_reg   <= cand_i.flush;
        end
        if (cand_i.valid && cand_ready_o) begin
            pend_x_reg      <= cand_i.x;
            pend_y_reg      <= cand_i.y;
            pend_colour_reg <= cand_i.colour;
        end
    end

    assign m_tvalid       = out_valid_reg;
    assign m_tlast        = out_last_reg;
    assign pixel_x_o      = out_x_reg;
    assign pixel_y_o      = out_y_reg;
    assign pixel_colour_o = out_colour_reg;

endmodule

`default_nettype wire
